>>> rtl/core/tms_pkg.sv
// shared constants, types and codes for the transform matrix stack
package tms_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int MAT_DIM     = 4;
	localparam int MAT_ELEMS   = MAT_DIM * MAT_DIM;
	localparam int DIM_W       = $clog2(MAT_DIM);
	localparam int IDX_W       = $clog2(MAT_ELEMS);
	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ST_WORDS    = STACK_DEPTH * MAT_ELEMS;
	localparam int ST_ADDR_W   = $clog2(ST_WORDS);
	localparam int PROD_W      = 2 * VALUE_WIDTH;
	localparam int ACC_W       = PROD_W + DIM_W;

	typedef logic [2:0]                    req_t;
	typedef logic [IDX_W-1:0]              idx_t;
	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [1:0]                    status_t;
	typedef logic [DIM_W-1:0]              dim_t;
	typedef logic [ST_ADDR_W-1:0]          st_addr_t;

	localparam req_t REQ_IDENTITY = 3'd0;
	localparam req_t REQ_ELEM     = 3'd1;
	localparam req_t REQ_PUSH     = 3'd2;
	localparam req_t REQ_POP      = 3'd3;
	localparam req_t REQ_GET      = 3'd4;

	localparam status_t STS_OK    = 2'd0;
	localparam status_t STS_FULL  = 2'd1;
	localparam status_t STS_EMPTY = 2'd2;

	// 1.0 in the fixed point format
	localparam value_t ONE_Q = value_t'(1) <<< FRAC_BITS;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
		dim_t row;
		dim_t col;
	} mac_tag_t;

	function automatic value_t identity_elem(input idx_t idx);
		value_t v;
		v = '0;
		if (idx[IDX_W-1 -: DIM_W] == idx[DIM_W-1:0])
			v = ONE_Q;
		return v;
	endfunction

endpackage

>>> rtl/core/transform_matrix_stack.sv
// top level: request sequencer, current and operand matrices, result register
//
// One command channel: an item (req_type, elem_index, elem_value) is taken on a
// rising edge with start high and busy low. Results appear on out_value,
// out_index, out_last and status, marked by strobe, high for one cycle per
// result; the receiver cannot stall, so results are presented, not waited on.
// Work per item, from acceptance to the registered result:
//   identity, operand element 0..14, push when full, pop when empty: the result
//   goes straight to the result register; busy stays low, so such items can be sent every cycle
//   get: a result for each element, 0 to 15 in order, out_last on the last one
//   push: one element copied per cycle through the store port, then the result
//   pop: one store read per cycle plus the registered read, then the result
//   operand element 15: the 64 multiply-accumulate steps go one per cycle through
//   a single 32x32 multiplier, then through the product and accumulator registers
//   and the result register
// Unused request codes give no result and leave busy low.
// Reset sets the current matrix to identity and empties the stack; the
// saved store and operand buffer hold whatever was last written.
module transform_matrix_stack (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tms_pkg::req_t   req_type,
	input  tms_pkg::idx_t   elem_index,
	input  tms_pkg::value_t elem_value,
	output logic            strobe,
	output tms_pkg::value_t out_value,
	output tms_pkg::idx_t   out_index,
	output logic            out_last,
	output tms_pkg::status_t status
);
	import tms_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_PUSH  = 3'd2;
	localparam logic [2:0] S_POP   = 3'd3;
	localparam logic [2:0] S_GET   = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;

	localparam idx_t LAST_IDX = idx_t'(MAT_ELEMS - 1);
	localparam dim_t LAST_DIM = dim_t'(MAT_DIM - 1);
	localparam int   STEP_W   = IDX_W + DIM_W;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CNT_W-1:0]  stack_cnt_q;
	value_t            cur_q [MAT_ELEMS];
	value_t            op_q [MAT_ELEMS];
	value_t            row_q [MAT_DIM-1];
	logic              pop_vld_s1;
	idx_t              pop_idx_s1;

	logic              accept;
	logic              full;
	logic              empty;
	idx_t              elem_cnt;
	dim_t              step_i;
	dim_t              step_j;
	dim_t              step_k;
	idx_t              cur_ridx;
	value_t            cur_rdata;
	value_t            op_rdata;
	mac_tag_t          mac_tag;
	mac_tag_t          mac_res_tag;
	value_t            mac_res;
	logic [CNT_W-1:0]  slot;
	st_addr_t          st_addr;
	value_t            st_rdata;
	logic              drain_done;

	logic              res_fire;
	value_t            res_value;
	idx_t              res_index;
	logic              res_last;
	status_t           res_status;
	logic              strobe_q;
	value_t            out_value_q;
	idx_t              out_index_q;
	logic              out_last_q;
	status_t           status_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (stack_cnt_q == CNT_W'(STACK_DEPTH));
	assign empty  = (stack_cnt_q == '0);

	// step counter as row, column, inner index of the product
	assign elem_cnt = cnt_q[IDX_W-1:0];
	assign step_i   = cnt_q[STEP_W-1 -: DIM_W];
	assign step_j   = cnt_q[2*DIM_W-1 -: DIM_W];
	assign step_k   = cnt_q[DIM_W-1:0];

	assign cur_ridx  = (state_q == S_MUL) ? {step_i, step_k} : elem_cnt;
	assign cur_rdata = cur_q[cur_ridx];
	assign op_rdata  = op_q[{step_k, step_j}];

	always_comb begin
		mac_tag.vld   = (state_q == S_MUL);
		mac_tag.first = (step_k == '0);
		mac_tag.last  = (step_k == LAST_DIM);
		mac_tag.row   = step_i;
		mac_tag.col   = step_j;
	end

	tms_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag     (mac_tag),
		.a       (cur_rdata),
		.b       (op_rdata),
		.res_tag (mac_res_tag),
		.res     (mac_res)
	);

	assign slot    = (state_q == S_PUSH) ? stack_cnt_q : stack_cnt_q - 1'b1;
	assign st_addr = (st_addr_t'(slot) << IDX_W) | st_addr_t'(elem_cnt);

	tms_stack u_stack (
		.clk   (clk),
		.we    (state_q == S_PUSH),
		.re    (state_q == S_POP),
		.addr  (st_addr),
		.wdata (cur_rdata),
		.rdata (st_rdata)
	);

	assign drain_done = (mac_res_tag.vld && mac_res_tag.row == LAST_DIM &&
		mac_res_tag.col == LAST_DIM) || (pop_vld_s1 && pop_idx_s1 == LAST_IDX);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			stack_cnt_q <= '0;
			pop_vld_s1  <= 1'b0;
		end else begin
			pop_vld_s1 <= (state_q == S_POP);
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						case (req_type)
							REQ_ELEM: begin
								if (elem_index == LAST_IDX)
									state_q <= S_MUL;
							end
							REQ_PUSH: begin
								if (!full)
									state_q <= S_PUSH;
							end
							REQ_POP: begin
								if (!empty)
									state_q <= S_POP;
							end
							REQ_GET: state_q <= S_GET;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1)
						state_q <= S_DRAIN;
				end
				S_PUSH: begin
					cnt_q <= cnt_q + 1'b1;
					if (elem_cnt == LAST_IDX) begin
						stack_cnt_q <= stack_cnt_q + 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_POP: begin
					cnt_q <= cnt_q + 1'b1;
					if (elem_cnt == LAST_IDX)
						state_q <= S_DRAIN;
				end
				S_GET: begin
					cnt_q <= cnt_q + 1'b1;
					if (elem_cnt == LAST_IDX)
						state_q <= S_IDLE;
				end
				S_DRAIN: begin
					if (drain_done) begin
						state_q <= S_IDLE;
						if (pop_vld_s1)
							stack_cnt_q <= stack_cnt_q - 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		pop_idx_s1 <= elem_cnt;
	end

	// operand buffer
	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_ELEM)
			op_q[elem_index] <= elem_value;
	end

	// finished product elements of the row in work, written back with the last one
	always_ff @(posedge clk) begin
		if (mac_res_tag.vld && mac_res_tag.col != LAST_DIM)
			row_q[mac_res_tag.col] <= mac_res;
	end

	// current matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < MAT_ELEMS; e++)
				cur_q[e] <= identity_elem(idx_t'(e));
		end else if (accept && req_type == REQ_IDENTITY) begin
			for (int e = 0; e < MAT_ELEMS; e++)
				cur_q[e] <= identity_elem(idx_t'(e));
		end else if (mac_res_tag.vld && mac_res_tag.col == LAST_DIM) begin
			for (int c = 0; c < MAT_DIM - 1; c++)
				cur_q[{mac_res_tag.row, dim_t'(c)}] <= row_q[c];
			cur_q[{mac_res_tag.row, LAST_DIM}] <= mac_res;
		end else if (pop_vld_s1) begin
			cur_q[pop_idx_s1] <= st_rdata;
		end
	end

	// result selection
	always_comb begin
		res_fire   = 1'b0;
		res_value  = '0;
		res_index  = '0;
		res_last   = 1'b1;
		res_status = STS_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_IDENTITY: res_fire = 1'b1;
						REQ_ELEM: res_fire = (elem_index != LAST_IDX);
						REQ_PUSH: begin
							res_fire   = full;
							res_status = STS_FULL;
						end
						REQ_POP: begin
							res_fire   = empty;
							res_status = STS_EMPTY;
						end
						default: res_fire = 1'b0;
					endcase
				end
			end
			S_GET: begin
				res_fire  = 1'b1;
				res_value = cur_rdata;
				res_index = elem_cnt;
				res_last  = (elem_cnt == LAST_IDX);
			end
			S_PUSH: res_fire = (elem_cnt == LAST_IDX);
			S_DRAIN: res_fire = drain_done;
			default: res_fire = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= res_fire;
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			out_value_q <= res_value;
			out_index_q <= res_index;
			out_last_q  <= res_last;
			status_q    <= res_status;
		end
	end

	assign strobe    = strobe_q;
	assign out_value = out_value_q;
	assign out_index = out_index_q;
	assign out_last  = out_last_q;
	assign status    = status_q;

endmodule

>>> rtl/core/tms_mac.sv
// shared multiply-accumulate unit: product, exact dot-product sum, floor and saturate
module tms_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  tms_pkg::mac_tag_t tag,
	input  tms_pkg::value_t   a,
	input  tms_pkg::value_t   b,
	output tms_pkg::mac_tag_t res_tag,
	output tms_pkg::value_t   res
);
	import tms_pkg::*;

	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_s2;
	logic signed [ACC_W-1:0]  shr;
	mac_tag_t                 tag_s1;
	mac_tag_t                 tag_s2;

	assign prod_c = a * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		if (tag_s1.vld) begin
			if (tag_s1.first)
				acc_s2 <= ACC_W'(prod_s1);
			else
				acc_s2 <= acc_s2 + ACC_W'(prod_s1);
		end
	end

	// floor of the exact sum, then clamp to the value range
	assign shr = acc_s2 >>> FRAC_BITS;

	always_comb begin
		if (shr > SAT_HI)
			res = SAT_HI[VALUE_WIDTH-1:0];
		else if (shr < SAT_LO)
			res = SAT_LO[VALUE_WIDTH-1:0];
		else
			res = shr[VALUE_WIDTH-1:0];
	end

	always_comb begin
		res_tag = tag_s2;
		res_tag.vld = tag_s2.vld && tag_s2.last;
	end

endmodule

>>> rtl/core/tms_stack.sv
// saved matrix store: one port, registered read
module tms_stack (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  tms_pkg::st_addr_t addr,
	input  tms_pkg::value_t   wdata,
	output tms_pkg::value_t   rdata
);
	import tms_pkg::*;

	value_t mem_q [ST_WORDS];
	value_t rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		if (re)
			rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule
